@@ rtl/sle_pkg.sv @@
// Shared types and constants of the sorted list engine.
// Used by the channel interfaces, the controller, the datapath and the checker.
package sle_pkg;

    localparam int MODE_W     = 2;
    localparam int VALUE_IN_W = 32;
    localparam int STATUS_W   = 2;
    localparam int POS_W      = 6;
    localparam int COUNT_W    = 7;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE,
        ST_NOT_FOUND,
        ST_EMPTY,
        ST_FULL
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_TAIL,
        S_RESULT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic latch;
        logic dispatch;
        logic scan;
        logic tail;
        logic load_out;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_scan;
        logic scan_done;
        logic need_tail;
    } t_dp_stat;

endpackage

@@ rtl/sle_if.sv @@
// Request and response channel interfaces of the sorted list engine.
// Depends on sle_pkg for field widths and the status type.
interface sle_req_if;
    logic                                   valid;
    logic                                   ready;
    logic [sle_pkg::MODE_W-1:0]             mode;
    logic signed [sle_pkg::VALUE_IN_W-1:0]  value;

    modport source (output valid, mode, value, input ready);
    modport sink   (input valid, mode, value, output ready);
endinterface

interface sle_rsp_if;
    logic                         valid;
    logic                         ready;
    sle_pkg::t_status             status;
    logic [sle_pkg::POS_W-1:0]    position;
    logic [sle_pkg::COUNT_W-1:0]  entry_count;

    modport source (output valid, status, position, entry_count, input ready);
    modport sink   (input valid, status, position, entry_count, output ready);
endinterface

@@ rtl/sle_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/sle_ctrl.sv @@
// Sequencer of the sorted list engine: request handshake, scan control, result register.
// Depends on sle_pkg; drives the datapath through t_dp_cmd.
module sle_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  sle_pkg::t_dp_stat i_stat,
    output sle_pkg::t_dp_cmd  o_cmd
);

    sle_pkg::t_state r_state;
    sle_pkg::t_state n_state;
    logic            r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sle_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            sle_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = sle_pkg::S_DISPATCH;
                end
            end
            sle_pkg::S_DISPATCH: begin
                o_cmd.dispatch = 1'b1;
                n_state = i_stat.need_scan ? sle_pkg::S_SCAN : sle_pkg::S_RESULT;
            end
            sle_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = i_stat.need_tail ? sle_pkg::S_TAIL : sle_pkg::S_RESULT;
                end
            end
            sle_pkg::S_TAIL: begin
                o_cmd.tail = 1'b1;
                n_state    = sle_pkg::S_RESULT;
            end
            sle_pkg::S_RESULT: begin
                // wait for the output slot to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = sle_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sle_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/sle_dp.sv @@
// Datapath of the sorted list engine: entry RAM, scan pointers, compare and result registers.
// Depends on sle_pkg and sle_ram; commanded by sle_ctrl.
module sle_dp #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  sle_pkg::t_dp_cmd                      i_cmd,
    output sle_pkg::t_dp_stat                     o_stat,
    input  logic [sle_pkg::MODE_W-1:0]            i_mode,
    input  logic signed [sle_pkg::VALUE_IN_W-1:0] i_value,
    output sle_pkg::t_status                      o_status,
    output logic [sle_pkg::POS_W-1:0]             o_position,
    output logic [sle_pkg::COUNT_W-1:0]           o_entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // control state
    logic [CW-1:0]                r_count;
    logic                         r_pvalid;
    logic                         r_found;
    // request and scan registers
    logic [sle_pkg::MODE_W-1:0]   r_mode;
    logic signed [VALUE_WIDTH-1:0] r_value;
    logic [AW-1:0]                r_rd_addr;
    logic [CW-1:0]                r_left;
    logic [AW-1:0]                r_pidx;
    sle_pkg::t_status             r_res_status;
    logic [AW-1:0]                r_res_pos;
    // output register
    sle_pkg::t_status             r_out_status;
    logic [sle_pkg::POS_W-1:0]    r_out_pos;
    logic [sle_pkg::COUNT_W-1:0]  r_out_count;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic                   ram_re;
    logic [VALUE_WIDTH-1:0] ram_rdata;

    logic          is_ins;
    logic          is_del;
    logic          is_srch;
    logic          cnt_zero;
    logic          cnt_full;
    logic [CW-1:0] cnt_m1;
    logic [AW-1:0] last_idx;
    logic          ge;
    logic          eq;
    logic          at_last;
    logic          at_zero;
    logic          issue;

    sle_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_addr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        is_ins   = (r_mode == sle_pkg::MODE_INSERT);
        is_del   = (r_mode == sle_pkg::MODE_DELETE);
        is_srch  = (r_mode == sle_pkg::MODE_SEARCH);
        cnt_zero = (r_count == '0);
        cnt_full = (r_count == CAP_C);
        cnt_m1   = r_count - 1'b1;
        last_idx = cnt_m1[AW-1:0];
        ge       = ($signed(ram_rdata) >= r_value);
        eq       = (ram_rdata == r_value);
        at_last  = (r_pidx == last_idx);
        at_zero  = (r_pidx == '0);
        issue    = i_cmd.scan && (r_left != '0);

        o_stat.need_scan = (is_ins && !cnt_full && !cnt_zero) ||
                           ((is_del || is_srch) && !cnt_zero);
        // insert walks down from the top, delete and search walk up from zero
        o_stat.scan_done = r_pvalid &&
                           (is_ins ? (!ge || at_zero) : (at_last || (is_srch && eq)));
        o_stat.need_tail = is_ins && ge;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = r_value;
        ram_re    = issue;
        if (i_cmd.dispatch && is_ins && cnt_zero) begin
            ram_we = 1'b1;
        end
        if (i_cmd.scan && r_pvalid) begin
            if (is_ins) begin
                // shift a larger entry up, or drop the new value into the gap
                ram_we    = 1'b1;
                ram_waddr = r_pidx + 1'b1;
                ram_wdata = ge ? ram_rdata : r_value;
            end else if (is_del && r_found) begin
                ram_we    = 1'b1;
                ram_waddr = r_pidx - 1'b1;
                ram_wdata = ram_rdata;
            end
        end
        if (i_cmd.tail) begin
            ram_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_pvalid <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            if (i_cmd.dispatch) begin
                r_pvalid <= 1'b0;
                r_found  <= 1'b0;
                if (is_ins && cnt_zero) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.scan) begin
                r_pvalid <= issue;
                if (r_pvalid) begin
                    if (is_ins) begin
                        if (!ge) begin
                            r_count <= r_count + 1'b1;
                        end
                    end else begin
                        if (eq) begin
                            r_found <= 1'b1;
                        end
                        if (at_last && is_del && (r_found || eq)) begin
                            r_count <= r_count - 1'b1;
                        end
                    end
                end
            end
            if (i_cmd.tail) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode  <= i_mode;
            r_value <= VALUE_WIDTH'(i_value);
        end
        if (i_cmd.dispatch) begin
            r_rd_addr <= is_ins ? last_idx : '0;
            r_left    <= r_count;
            r_res_pos <= '0;
            if (is_ins) begin
                r_res_status <= cnt_full ? sle_pkg::ST_FULL : sle_pkg::ST_DONE;
            end else if (is_del || is_srch) begin
                r_res_status <= cnt_zero ? sle_pkg::ST_EMPTY : sle_pkg::ST_NOT_FOUND;
            end else begin
                r_res_status <= sle_pkg::ST_NOT_FOUND;
            end
        end
        if (i_cmd.scan) begin
            if (issue) begin
                r_rd_addr <= is_ins ? r_rd_addr - 1'b1 : r_rd_addr + 1'b1;
                r_left    <= r_left - 1'b1;
            end
            r_pidx <= r_rd_addr;
            if (r_pvalid) begin
                if (is_ins) begin
                    if (!ge) begin
                        r_res_pos <= r_pidx + 1'b1;
                    end
                end else begin
                    if (!r_found && eq) begin
                        r_res_pos <= r_pidx;
                    end
                    if ((at_last || (is_srch && eq)) && (r_found || eq)) begin
                        r_res_status <= sle_pkg::ST_DONE;
                    end
                end
            end
        end
        if (i_cmd.tail) begin
            r_res_pos <= '0;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_pos    <= sle_pkg::POS_W'(r_res_pos);
            r_out_count  <= sle_pkg::COUNT_W'(r_count);
        end
    end

    assign o_status      = r_out_status;
    assign o_position    = r_out_pos;
    assign o_entry_count = r_out_count;

endmodule

@@ rtl/sorted_list_engine_top.sv @@
// Sorted list engine: bounded ascending list of signed values with insert,
// delete and search requests.
//
// Channels: i_req (mode, value) and o_rsp (status, position, entry_count),
// both valid/ready; a beat moves at a clock edge with valid and ready high.
// Every request beat yields exactly one response beat.
//
// Timing: one request is worked at a time. A request that needs no scan
// (full insert, empty delete or search, unused mode, insert into an empty
// list) goes from the dispatch state straight to the result state.
// Otherwise the entries are streamed through the single read port of the
// entry RAM, one per cycle, while for an insert or a delete the write port
// shifts them.
//
// The response sits in an output register; the next request is accepted
// while it waits. A stalled receiver holds the response steady and only
// blocks the engine when a second response is ready to load.
//
// Reset (i_rst_n low, synchronous) empties the list; RAM contents are left
// as they are and are never read beyond the entry count.
module sorted_list_engine_top #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input logic       i_clk,
    input logic       i_rst_n,
    sle_req_if.sink   i_req,
    sle_rsp_if.source o_rsp
);

    sle_pkg::t_dp_cmd  cmd;
    sle_pkg::t_dp_stat stat;

    sle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    sle_dp #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_mode        (i_req.mode),
        .i_value       (i_req.value),
        .o_status      (o_rsp.status),
        .o_position    (o_rsp.position),
        .o_entry_count (o_rsp.entry_count)
    );

endmodule

@@ rtl/sle_checker.sv @@
// Port-level assertions for the sorted list engine, bound to its top level.
// Depends on sle_pkg for status codes.
module sle_checker #(
    parameter int CAPACITY = 64
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input sle_pkg::t_status             i_rsp_status,
    input logic [sle_pkg::POS_W-1:0]    i_rsp_position,
    input logic [sle_pkg::COUNT_W-1:0]  i_rsp_entry_count
);

    // stalled response beat stays put
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status) &&
            $stable(i_rsp_position) && $stable(i_rsp_entry_count))
        else $error("response changed while stalled");

    // one request in flight: ready drops right after a request beat
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted while another is in flight");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status == sle_pkg::ST_FULL) |->
            (i_rsp_entry_count == sle_pkg::COUNT_W'(CAPACITY)))
        else $error("full status with wrong entry count");

    a_miss_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && ((i_rsp_status == sle_pkg::ST_NOT_FOUND) ||
            (i_rsp_status == sle_pkg::ST_EMPTY) || (i_rsp_status == sle_pkg::ST_FULL)) |->
            (i_rsp_position == '0))
        else $error("nonzero position on a failed request");

endmodule

bind sorted_list_engine_top sle_checker #(
    .CAPACITY (CAPACITY)
) u_sle_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_status      (o_rsp.status),
    .i_rsp_position    (o_rsp.position),
    .i_rsp_entry_count (o_rsp.entry_count)
);

@@ tb/sorted_list_engine_top_test.sv @@
// Testbench for sorted_list_engine_top: directed and random insert, delete and search beats.
// A shadow list predicts each reply, and the replies are checked in order.
// Depends on sle_pkg, the sle_req_if/sle_rsp_if interfaces and the engine top level.
module sorted_list_engine_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_CAPACITY = 64;
    localparam logic [sle_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic signed [sle_pkg::VALUE_IN_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [sle_pkg::VALUE_IN_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        sle_pkg::t_status                 status;
        logic [sle_pkg::POS_W-1:0]        position;
        logic [sle_pkg::COUNT_W-1:0]      entry_count;
    } t_reply;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sle_req_if req_ch();
    sle_rsp_if rsp_ch();

    sorted_list_engine_top #(
        .CAPACITY    (LIST_CAPACITY),
        .VALUE_WIDTH (sle_pkg::VALUE_IN_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // shadow of the engine's list, ascending
    logic signed [sle_pkg::VALUE_IN_W-1:0] shadow_list[$];
    t_reply pending_replies[$];
    t_reply want_reply;
    int     mismatch_cnt = 0;
    bit     req_gaps_on = 1'b0;
    bit     rsp_stalls_on = 1'b0;
    int     rsp_stall_left = 0;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.mode  = sle_pkg::MODE_INSERT;
        req_ch.value = '0;
        rsp_ch.ready = 1'b0;
    end

    // mostly short idles, a few long ones
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 60);
    endfunction

    // Applies one request to the shadow list and returns the reply it must produce.
    function automatic t_reply predict_list_reply(logic [sle_pkg::MODE_W-1:0] mode,
                                                  logic signed [sle_pkg::VALUE_IN_W-1:0] value);
        t_reply r;
        int     idx;
        r.status   = sle_pkg::ST_NOT_FOUND;
        r.position = '0;
        idx = 0;
        if (mode == sle_pkg::MODE_INSERT) begin
            if (shadow_list.size() >= LIST_CAPACITY) begin
                r.status = sle_pkg::ST_FULL;
            end else begin
                // goes before the first entry that is not smaller, so ahead of duplicates
                while (idx < shadow_list.size() && shadow_list[idx] < value)
                    idx++;
                shadow_list.insert(idx, value);
                r.status   = sle_pkg::ST_DONE;
                r.position = idx[sle_pkg::POS_W-1:0];
            end
        end else if (mode == sle_pkg::MODE_DELETE || mode == sle_pkg::MODE_SEARCH) begin
            if (shadow_list.size() == 0) begin
                r.status = sle_pkg::ST_EMPTY;
            end else begin
                while (idx < shadow_list.size() && shadow_list[idx] != value)
                    idx++;
                if (idx < shadow_list.size()) begin
                    r.status   = sle_pkg::ST_DONE;
                    r.position = idx[sle_pkg::POS_W-1:0];
                    if (mode == sle_pkg::MODE_DELETE)
                        shadow_list.delete(idx);
                end
            end
        end
        r.entry_count = sle_pkg::COUNT_W'(shadow_list.size());
        return r;
    endfunction

    // Drives one request beat at the falling edge and predicts its reply on acceptance.
    task automatic send_request(input logic [sle_pkg::MODE_W-1:0] mode,
                                input logic signed [sle_pkg::VALUE_IN_W-1:0] value);
        int gap;
        gap = req_gaps_on ? pick_idle_len() : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode  <= mode;
        req_ch.value <= value;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_replies.push_back(predict_list_reply(mode, value));
        @(negedge i_clk);
    endtask

    // Favors values already in the list so deletes and searches hit.
    function automatic logic signed [sle_pkg::VALUE_IN_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40 && shadow_list.size() > 0)
            return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
        else if (r < 65)
            return $signed($urandom_range(0, 32)) - 16;
        else if (r < 75) begin
            case ($urandom_range(0, 3))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return '0;
                default: return -1;
            endcase
        end
        return $signed($urandom());
    endfunction

    function automatic logic [sle_pkg::MODE_W-1:0] pick_mode(int ins_pct, int del_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return MODE_UNUSED;
        else if (r < 3 + ins_pct)
            return sle_pkg::MODE_INSERT;
        else if (r < 3 + ins_pct + del_pct)
            return sle_pkg::MODE_DELETE;
        return sle_pkg::MODE_SEARCH;
    endfunction

    // receiver stalls
    always @(negedge i_clk) begin
        if (!rsp_stalls_on) begin
            rsp_ch.ready <= 1'b1;
        end else if (rsp_stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall_left = rsp_stall_left - 1;
        end else begin
            rsp_stall_left = pick_idle_len();
            rsp_ch.ready <= (rsp_stall_left == 0);
            if (rsp_stall_left > 0)
                rsp_stall_left = rsp_stall_left - 1;
        end
    end

    // reply checker
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_replies.size() == 0) begin
                $error("reply beat with nothing pending");
                mismatch_cnt++;
            end else begin
                want_reply = pending_replies.pop_front();
                if (rsp_ch.status !== want_reply.status) begin
                    $error("status: expected %0d, got %0d", want_reply.status, rsp_ch.status);
                    mismatch_cnt++;
                end
                if (rsp_ch.position !== want_reply.position) begin
                    $error("position: expected %0d, got %0d",
                           want_reply.position, rsp_ch.position);
                    mismatch_cnt++;
                end
                if (rsp_ch.entry_count !== want_reply.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want_reply.entry_count, rsp_ch.entry_count);
                    mismatch_cnt++;
                end
            end
        end
    end

    task automatic test_empty_list();
        send_request(sle_pkg::MODE_SEARCH, '0);
        send_request(sle_pkg::MODE_DELETE, VAL_MIN);
        send_request(MODE_UNUSED, 32'sd5);
    endtask

    task automatic test_directed_ops();
        send_request(sle_pkg::MODE_INSERT, '0);      // insert into empty list
        send_request(sle_pkg::MODE_INSERT, VAL_MAX);
        send_request(sle_pkg::MODE_INSERT, VAL_MIN);
        send_request(sle_pkg::MODE_INSERT, -1);
        send_request(sle_pkg::MODE_INSERT, 32'sd7);
        send_request(sle_pkg::MODE_INSERT, 32'sd7);  // duplicate lands ahead of the equal one
        send_request(sle_pkg::MODE_INSERT, 32'sd1);
        send_request(sle_pkg::MODE_SEARCH, 32'sd7);
        send_request(sle_pkg::MODE_SEARCH, 32'sd100);
        send_request(sle_pkg::MODE_DELETE, 32'sd100);
        send_request(MODE_UNUSED, 32'sd7);
        send_request(sle_pkg::MODE_DELETE, VAL_MIN);
        send_request(sle_pkg::MODE_DELETE, VAL_MAX);
        send_request(sle_pkg::MODE_DELETE, 32'sd7);
        send_request(sle_pkg::MODE_SEARCH, 32'sd7);
        send_request(sle_pkg::MODE_INSERT, 32'sh5555_5555);
        send_request(sle_pkg::MODE_INSERT, 32'shAAAA_AAAA);
        send_request(sle_pkg::MODE_SEARCH, 32'shAAAA_AAAA);
    endtask

    task automatic test_full_list();
        while (shadow_list.size() < LIST_CAPACITY)
            send_request(sle_pkg::MODE_INSERT, pick_value());
        send_request(sle_pkg::MODE_INSERT, VAL_MAX);
        send_request(sle_pkg::MODE_INSERT, VAL_MIN);
        send_request(sle_pkg::MODE_SEARCH, shadow_list[LIST_CAPACITY - 1]);
        send_request(MODE_UNUSED, '0);
        send_request(sle_pkg::MODE_DELETE, shadow_list[LIST_CAPACITY / 2]);
        send_request(sle_pkg::MODE_INSERT, pick_value());
        send_request(sle_pkg::MODE_INSERT, pick_value());
    endtask

    task automatic test_drain_list();
        while (shadow_list.size() > 0) begin
            if ($urandom_range(0, 9) < 8)
                send_request(sle_pkg::MODE_DELETE,
                             shadow_list[$urandom_range(0, shadow_list.size() - 1)]);
            else
                send_request(sle_pkg::MODE_SEARCH, pick_value());
        end
        send_request(sle_pkg::MODE_DELETE, pick_value());
        send_request(sle_pkg::MODE_SEARCH, pick_value());
    endtask

    task automatic test_random_mix(int n_items, int ins_pct, int del_pct);
        repeat (n_items)
            send_request(pick_mode(ins_pct, del_pct), pick_value());
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_list();
        test_directed_ops();
        req_gaps_on   = 1'b1;
        rsp_stalls_on = 1'b1;
        test_full_list();
        test_drain_list();
        req_gaps_on   = 1'b0;
        rsp_stalls_on = 1'b0;
        test_random_mix(180, 45, 25);
        req_gaps_on   = 1'b1;
        rsp_stalls_on = 1'b1;
        test_random_mix(200, 65, 15);   // tends to run into the full list
        test_random_mix(200, 15, 60);   // tends to run the list empty
        req_gaps_on   = 1'b0;
        test_random_mix(100, 40, 30);
        req_gaps_on   = 1'b1;
        rsp_stalls_on = 1'b0;
        test_random_mix(100, 40, 30);
        rsp_stalls_on = 1'b1;
        test_random_mix(80, 35, 35);

        req_ch.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

@@ files.f @@
rtl/sle_pkg.sv
rtl/sle_if.sv
rtl/sle_ram.sv
rtl/sle_ctrl.sv
rtl/sle_dp.sv
rtl/sorted_list_engine_top.sv
rtl/sle_checker.sv
tb/sorted_list_engine_top_test.sv
